[hw/rtl/adjacent_line_run_filter_defines.svh]
// Assertion macros used by the checker file.
`ifndef ADJACENT_LINE_RUN_FILTER_DEFINES_SVH
`define ADJACENT_LINE_RUN_FILTER_DEFINES_SVH

// Same-cycle implication, quiet during reset.
`define ALRF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("alrf: same-cycle check failed");

// Next-cycle implication, quiet during reset.
`define ALRF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("alrf: next-cycle check failed");

// Next-cycle implication that also looks at the reset itself.
`define ALRF_ASSERT_RESET(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("alrf: reset check failed");

`endif

[hw/rtl/alrf_pkg.sv]
`default_nettype none

package alrf_pkg;

    localparam int MAX_COMPARE = 256;
    localparam int ADDR_W      = $clog2(MAX_COMPARE);
    localparam int POS_W       = $clog2(MAX_COMPARE + 1);

    // Descriptor queue: room for the two descriptors one request may raise.
    localparam int RES_PER_ITEM = 2;
    localparam int DESC_DEPTH   = 4;
    localparam int DPTR_W       = $clog2(DESC_DEPTH);
    localparam int DCNT_W       = $clog2(DESC_DEPTH + 1);

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_TAB     = 8'h09;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SKIP_FIELDS   = 8'd0,
        CFG_SKIP_BYTES    = 8'd1,
        CFG_ONLY_REPEATED = 8'd2,
        CFG_ONLY_SINGLE   = 8'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0]  skip_fields;
        logic [15:0] skip_bytes;
        logic        only_repeated;
        logic        only_single;
    } t_cfg;

    typedef struct packed {
        logic [31:0] run_first_line;
        logic [31:0] run_length;
        logic        compare_truncated;
        logic        final_result;
    } t_desc;

    // Up to two descriptors leave the line stage per request, a before b.
    typedef struct packed {
        logic  a_valid;
        t_desc a;
        logic  b_valid;
        t_desc b;
    } t_push;

    typedef struct packed {
        logic              wr_en;
        logic              cmp_en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } t_store_req;

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        sat_inc = (v == '1) ? v : v + 32'd1;
    endfunction

    function automatic logic run_passes(input logic [31:0] cnt, input t_cfg cfg);
        run_passes = !((cfg.only_repeated && cnt < 32'd2) ||
                       (cfg.only_single && cnt != 32'd1));
    endfunction

endpackage

`default_nettype wire

[hw/rtl/alrf_ifs.sv]
`default_nettype none

interface alrf_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       stream_end;
    modport source (output valid, output data_byte, output stream_end, input ready);
    modport sink (input valid, input data_byte, input stream_end, output ready);
endinterface

interface alrf_desc_if;
    logic        valid;
    logic        ready;
    logic [31:0] run_first_line;
    logic [31:0] run_length;
    logic        compare_truncated;
    logic        final_result;
    modport source (output valid, output run_first_line, output run_length,
                    output compare_truncated, output final_result, input ready);
    modport sink (input valid, input run_first_line, input run_length,
                  input compare_truncated, input final_result, output ready);
endinterface

interface alrf_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [15:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[hw/rtl/alrf_cmp_store.sv]
`default_nettype none

// Held compare bytes: read old byte and write new byte at one address per cycle,
// report a mismatch in the following cycle.
module alrf_cmp_store import alrf_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_store_req i_req,
    output logic            o_mismatch
);

    logic [7:0] r_mem [MAX_COMPARE];
    logic [7:0] r_rdata;
    logic [7:0] r_wdata;
    logic       r_pend;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.addr] <= i_req.data;
        end
        r_rdata <= r_mem[i_req.addr];
        r_wdata <= i_req.data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else begin
            r_pend <= i_req.cmp_en;
        end
    end

    assign o_mismatch = r_pend && (r_rdata != r_wdata);

endmodule

`default_nettype wire

[hw/rtl/alrf_line_ctl.sv]
`default_nettype none

// Input register and per-line state: field/byte skipping, run tracking,
// descriptor generation.
module alrf_line_ctl import alrf_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_stream_end,
    input  wire t_cfg       i_cfg,
    input  wire logic       i_mismatch,
    output t_store_req      o_store,
    output t_push           o_push,
    output logic            o_busy
);

    logic             r_s1_valid;
    logic [7:0]       r_s1_byte;
    logic             r_s1_end;

    logic [POS_W-1:0] r_held_len, n_held_len;
    logic [POS_W-1:0] r_pos, n_pos;
    logic             r_line_differs, n_line_differs;
    logic [7:0]       r_fields_left, n_fields_left;
    logic             r_seen_nonblank, n_seen_nonblank;
    logic [15:0]      r_bytes_left, n_bytes_left;
    logic             r_have_run, n_have_run;
    logic [31:0]      r_run_cnt, n_run_cnt;
    logic [31:0]      r_run_start, n_run_start;
    logic [31:0]      r_line_num, n_line_num;
    logic             r_line_has_bytes, n_line_has_bytes;
    logic             r_line_trunc, n_line_trunc;
    logic             r_run_trunc, n_run_trunc;

    logic             diff_eff;
    logic             el_differ;
    logic             el_emit;
    logic [31:0]      el_cnt;
    logic [31:0]      el_start;
    logic             el_trunc;
    logic             fin_have;
    logic [31:0]      fin_cnt;
    logic [31:0]      fin_start;
    logic             fin_trunc;
    logic             fin_emit;
    logic             blank;
    logic             go;
    logic [7:0]       fl;
    logic [15:0]      bl;
    logic             sn;

    assign o_busy = r_s1_valid;
    assign blank  = (r_s1_byte == CHAR_SPACE) || (r_s1_byte == CHAR_TAB);

    // Outcome of closing the current line.
    always_comb begin
        diff_eff  = r_line_differs | i_mismatch;
        el_differ = !r_have_run || diff_eff || (r_pos != r_held_len);
        el_emit   = el_differ && r_have_run && run_passes(r_run_cnt, i_cfg);
        el_cnt    = el_differ ? 32'd1 : sat_inc(r_run_cnt);
        el_start  = el_differ ? r_line_num : r_run_start;
        el_trunc  = el_differ ? r_line_trunc : (r_run_trunc | r_line_trunc);
        fin_have  = r_line_has_bytes | r_have_run;
        fin_cnt   = r_line_has_bytes ? el_cnt : r_run_cnt;
        fin_start = r_line_has_bytes ? el_start : r_run_start;
        fin_trunc = r_line_has_bytes ? el_trunc : r_run_trunc;
        fin_emit  = fin_have && run_passes(fin_cnt, i_cfg);
    end

    always_comb begin
        n_held_len       = r_held_len;
        n_pos            = r_pos;
        n_line_differs   = diff_eff;
        n_fields_left    = r_fields_left;
        n_seen_nonblank  = r_seen_nonblank;
        n_bytes_left     = r_bytes_left;
        n_have_run       = r_have_run;
        n_run_cnt        = r_run_cnt;
        n_run_start      = r_run_start;
        n_line_num       = r_line_num;
        n_line_has_bytes = r_line_has_bytes;
        n_line_trunc     = r_line_trunc;
        n_run_trunc      = r_run_trunc;
        o_push           = '0;
        o_store          = '0;
        o_store.addr     = r_pos[ADDR_W-1:0];
        o_store.data     = r_s1_byte;
        fl               = r_line_has_bytes ? r_fields_left : i_cfg.skip_fields;
        bl               = r_line_has_bytes ? r_bytes_left : i_cfg.skip_bytes;
        sn               = r_line_has_bytes & r_seen_nonblank;
        go               = 1'b0;

        if (r_s1_valid) begin
            if (r_s1_end || r_s1_byte == CHAR_NEWLINE) begin
                o_push.a = '{run_first_line: r_run_start, run_length: r_run_cnt,
                             compare_truncated: r_run_trunc, final_result: 1'b0};
                n_held_len       = el_differ ? r_pos : r_held_len;
                n_have_run       = 1'b1;
                n_run_cnt        = el_cnt;
                n_run_start      = el_start;
                n_run_trunc      = el_trunc;
                n_line_num       = sat_inc(r_line_num);
                n_pos            = '0;
                n_line_differs   = 1'b0;
                n_fields_left    = '0;
                n_seen_nonblank  = 1'b0;
                n_bytes_left     = '0;
                n_line_has_bytes = 1'b0;
                n_line_trunc     = 1'b0;
                if (r_s1_end) begin
                    // Flush the held run, then the run holding the fragment; mark the last descriptor.
                    o_push.a_valid        = r_line_has_bytes && el_emit;
                    o_push.a.final_result = !fin_emit;
                    o_push.b_valid        = fin_emit;
                    o_push.b = '{run_first_line: fin_start, run_length: fin_cnt,
                                 compare_truncated: fin_trunc, final_result: 1'b1};
                    n_held_len  = '0;
                    n_have_run  = 1'b0;
                    n_run_cnt   = '0;
                    n_run_start = '0;
                    n_run_trunc = 1'b0;
                    n_line_num  = '0;
                end else begin
                    o_push.a_valid = el_emit;
                end
            end else begin
                n_line_has_bytes = 1'b1;
                if (fl != 8'd0) begin
                    if (!blank) begin
                        sn = 1'b1;
                    end else if (sn) begin
                        fl = fl - 8'd1;
                        sn = 1'b0;
                        go = (fl == 8'd0);
                    end
                end else begin
                    go = 1'b1;
                end
                if (go) begin
                    if (bl != 16'd0) begin
                        bl = bl - 16'd1;
                    end else if (r_pos < POS_W'(MAX_COMPARE)) begin
                        o_store.wr_en = 1'b1;
                        if (r_pos >= r_held_len) begin
                            n_line_differs = 1'b1;
                        end else begin
                            o_store.cmp_en = 1'b1;
                        end
                        n_pos = r_pos + POS_W'(1);
                    end else begin
                        n_line_trunc = 1'b1;
                    end
                end
                n_fields_left   = fl;
                n_bytes_left    = bl;
                n_seen_nonblank = sn;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1_byte <= i_data_byte;
            r_s1_end  <= i_stream_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid       <= 1'b0;
            r_held_len       <= '0;
            r_pos            <= '0;
            r_line_differs   <= 1'b0;
            r_fields_left    <= '0;
            r_seen_nonblank  <= 1'b0;
            r_bytes_left     <= '0;
            r_have_run       <= 1'b0;
            r_run_cnt        <= '0;
            r_run_start      <= '0;
            r_line_num       <= '0;
            r_line_has_bytes <= 1'b0;
            r_line_trunc     <= 1'b0;
            r_run_trunc      <= 1'b0;
        end else begin
            r_s1_valid       <= i_accept;
            r_held_len       <= n_held_len;
            r_pos            <= n_pos;
            r_line_differs   <= n_line_differs;
            r_fields_left    <= n_fields_left;
            r_seen_nonblank  <= n_seen_nonblank;
            r_bytes_left     <= n_bytes_left;
            r_have_run       <= n_have_run;
            r_run_cnt        <= n_run_cnt;
            r_run_start      <= n_run_start;
            r_line_num       <= n_line_num;
            r_line_has_bytes <= n_line_has_bytes;
            r_line_trunc     <= n_line_trunc;
            r_run_trunc      <= n_run_trunc;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/alrf_desc_fifo.sv]
`default_nettype none

// Small descriptor queue: push up to two per cycle, pop one.
module alrf_desc_fifo import alrf_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_push       i_push,
    input  wire logic        i_pop_ready,
    output logic             o_valid,
    output t_desc            o_desc,
    output logic [DCNT_W-1:0] o_count
);

    t_desc             r_entries [DESC_DEPTH];
    logic [DPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [DPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [DCNT_W-1:0] r_count, n_count;
    logic              pop;
    logic              push_any;
    logic              push_two;
    t_desc             first;

    assign o_valid  = (r_count != '0);
    assign o_desc   = r_entries[r_rd_ptr];
    assign o_count  = r_count;
    assign pop      = o_valid && i_pop_ready;
    assign push_any = i_push.a_valid | i_push.b_valid;
    assign push_two = i_push.a_valid & i_push.b_valid;
    assign first    = i_push.a_valid ? i_push.a : i_push.b;

    always_comb begin
        n_wr_ptr = r_wr_ptr + {{(DPTR_W-1){1'b0}}, push_any} +
                   {{(DPTR_W-1){1'b0}}, push_two};
        n_rd_ptr = r_rd_ptr + {{(DPTR_W-1){1'b0}}, pop};
        n_count  = r_count + {{(DCNT_W-1){1'b0}}, push_any} +
                   {{(DCNT_W-1){1'b0}}, push_two} - {{(DCNT_W-1){1'b0}}, pop};
    end

    always_ff @(posedge i_clk) begin
        if (push_any) begin
            r_entries[r_wr_ptr] <= first;
        end
        if (push_two) begin
            r_entries[r_wr_ptr + DPTR_W'(1)] <= i_push.b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/adjacent_line_run_filter.sv]
// Adjacent duplicate line filter over a byte stream.
// i_in carries one text byte per request; a newline ends a line, and a request
// with stream_end set closes the stream (fragment and last run are flushed).
// o_out carries one run descriptor per request: first line number, run length,
// truncation flag and a final mark on the last descriptor of a stream.
// i_cfg writes the skip counts and the two filter bits; it is always ready and
// should only be used while the block is idle.
// Throughput: one byte per cycle while i_in.ready is high, set by the held-line
// store, which reads the old byte and writes the new one at a single address
// each cycle; the compare result folds into the line state the next cycle.
// Path: the request ending a run passes the input register, its descriptors are
// written into the queue, and o_out offers them from there.
// A stream end can raise two descriptors at once.
// Stalls: descriptors wait in a four-entry queue; i_in.ready drops unless the
// queue can take two descriptors for the line stage request and two more.
// Reset (synchronous, active low): no run, line count zero, queue empty,
// configuration cleared. The store itself needs no clearing.
`default_nettype none

module adjacent_line_run_filter import alrf_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    alrf_byte_if.sink  i_in,
    alrf_desc_if.source o_out,
    alrf_cfg_if.sink   i_cfg
);

    t_cfg              r_cfg;
    t_store_req        store_req;
    t_push             push;
    t_desc             head;
    logic              mismatch;
    logic              busy;
    logic              accept;
    logic [DCNT_W-1:0] q_count;
    logic [DCNT_W:0]   q_claim;

    // Reserve queue room for the request in the line stage and the one behind it.
    assign q_claim    = {1'b0, q_count} + (busy ? (DCNT_W+1)'(RES_PER_ITEM) : '0);
    assign i_in.ready = (q_claim <= (DCNT_W+1)'(DESC_DEPTH - RES_PER_ITEM));
    assign accept     = i_in.valid && i_in.ready;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_SKIP_FIELDS:   r_cfg.skip_fields   <= i_cfg.data[7:0];
                CFG_SKIP_BYTES:    r_cfg.skip_bytes    <= i_cfg.data;
                CFG_ONLY_REPEATED: r_cfg.only_repeated <= i_cfg.data[0];
                CFG_ONLY_SINGLE:   r_cfg.only_single   <= i_cfg.data[0];
                default: begin
                    // drop writes to unknown registers
                end
            endcase
        end
    end

    alrf_line_ctl u_line_ctl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_data_byte  (i_in.data_byte),
        .i_stream_end (i_in.stream_end),
        .i_cfg        (r_cfg),
        .i_mismatch   (mismatch),
        .o_store      (store_req),
        .o_push       (push),
        .o_busy       (busy)
    );

    alrf_cmp_store u_cmp_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (store_req),
        .o_mismatch (mismatch)
    );

    alrf_desc_fifo u_desc_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_pop_ready (o_out.ready),
        .o_valid     (o_out.valid),
        .o_desc      (head),
        .o_count     (q_count)
    );

    assign o_out.run_first_line    = head.run_first_line;
    assign o_out.run_length        = head.run_length;
    assign o_out.compare_truncated = head.compare_truncated;
    assign o_out.final_result      = head.final_result;

endmodule

`default_nettype wire

[hw/rtl/alrf_checker.sv]
`default_nettype none
`include "adjacent_line_run_filter_defines.svh"

module alrf_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [31:0] i_run_first_line,
    input wire logic [31:0] i_run_length,
    input wire logic        i_in_ready
);

    logic        out_stalled;
    logic [63:0] head_bits;

    assign out_stalled = i_out_valid && !i_out_ready;
    assign head_bits   = {i_run_first_line, i_run_length};

    // A stalled descriptor stays offered and unchanged.
    `ALRF_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stalled, i_out_valid)
    `ALRF_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, out_stalled, $stable(head_bits))
    // Every run holds at least one line.
    `ALRF_ASSERT_NOW(a_len_nonzero, i_clk, i_rst_n, i_out_valid, i_run_length != 32'd0)
    // Reset empties the queue and opens the input.
    `ALRF_ASSERT_RESET(a_reset_empty, i_clk, !i_rst_n, !i_out_valid && i_in_ready)

endmodule

bind adjacent_line_run_filter alrf_checker u_alrf_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_run_first_line (o_out.run_first_line),
    .i_run_length     (o_out.run_length),
    .i_in_ready       (i_in.ready)
);

`default_nettype wire
